// ----- rtl/prsa_pkg.sv -----
package prsa_pkg;

   localparam int MAX_SLOTS_DEFAULT = 16;

   localparam int ADDR_W   = 32;
   localparam int DOMAIN_W = 3;
   localparam int REGION_W = 9;
   localparam int ACTIVE_W = 5;
   localparam int BASE_W   = 8;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 8;

   localparam logic [ADDR_W-1:0]   FREE_ADDR      = 32'hffff_ffff;
   localparam logic [DOMAIN_W-1:0] DOMAIN_NONE    = 3'd0;
   localparam logic [DOMAIN_W-1:0] DOMAIN_APPS_NS = 3'd1;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;
   localparam logic [BASE_W-1:0]   BASE_RESET   = 8'd0;

   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_SLOTS = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_BASE  = 4'd1;

   typedef struct packed {
      logic [ADDR_W-1:0]   range_base;
      logic [ADDR_W-1:0]   range_end;
      logic [DOMAIN_W-1:0] owner;
   } slot_entry_type;

   localparam slot_entry_type SLOT_FREE = '{
      range_base: FREE_ADDR,
      range_end:  FREE_ADDR,
      owner:      DOMAIN_NONE
   };

endpackage

// ----- rtl/protection_region_slot_allocator_core.sv -----
// Channel   Ports                               Transfer
// request   start, busy, req_*                  start high while busy low
// result    rsp_strobe, rsp_*                   one cycle at rsp_strobe, no stall
// config    csr_write_enable, csr_index, csr_*  every edge with csr_write_enable
//
// A request keeps busy high while it scans the N active slots, N being the
// active slot count (clamped to MAX_SLOTS), and stops at an exact match; the
// result strobes in the first cycle with busy low. The scan reads one slot
// per cycle via the single read port of the slot memory into a read register;
// the slot is written in the finish state, entered directly with no active slot.
// Reset marks every slot free at once through per-slot valid bits.
// The receiver cannot stall, so a result is never held back.
module protection_region_slot_allocator_core
   import prsa_pkg::*;
#(
   parameter int MAX_SLOTS = MAX_SLOTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [ADDR_W-1:0]     req_start_address,
   input  logic [ADDR_W-1:0]     req_end_address,
   input  logic [DOMAIN_W-1:0]   req_owner_domain,
   input  logic [DOMAIN_W-1:0]   req_read_domain,
   input  logic [DOMAIN_W-1:0]   req_write_domain,
   output logic                  rsp_strobe,
   output logic                  rsp_status,
   output logic [REGION_W-1:0]   rsp_region_number,
   output logic                  rsp_slot_freed,
   output logic [DOMAIN_W-1:0]   rsp_lock_read_domain,
   output logic [DOMAIN_W-1:0]   rsp_lock_write_domain,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W = $clog2(MAX_SLOTS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_SLOTS - 1);
   localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_SLOTS);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   // Configuration registers.
   logic [ACTIVE_W-1:0] active_slots_ff;
   logic [BASE_W-1:0]   region_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_slots_ff <= ACTIVE_RESET;
         region_base_ff  <= BASE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ACTIVE_SLOTS: active_slots_ff <= csr_write_data[ACTIVE_W-1:0];
            CSR_REGION_BASE:  region_base_ff  <= csr_write_data[BASE_W-1:0];
            default: ;
         endcase
      end
   end

   // Control and request registers.
   logic [1:0]          state_ff, state_in;
   logic [IDX_W-1:0]    scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0]    cmp_idx_ff, cmp_idx_in;
   logic                cmp_ok_ff, cmp_ok_in;
   logic [IDX_W-1:0]    first_ff, first_in;
   logic [IDX_W-1:0]    pick_ff, pick_in;
   logic                found_ff, found_in;
   logic                freed_ff, freed_in;

   logic [ADDR_W-1:0]   rq_start_ff, rq_end_ff;
   logic [DOMAIN_W-1:0] rq_owner_ff, rq_read_ff, rq_write_ff;

   // Slot memory with per-slot valid bits; an invalid slot reads as free.
   slot_entry_type      slot_mem [MAX_SLOTS];
   logic [MAX_SLOTS-1:0] slot_valid_ff;
   slot_entry_type      rd_data_ff;
   logic                rd_valid_ff;
   slot_entry_type      cur_slot;
   slot_entry_type      wr_entry;

   logic                accept;
   logic [CNT_W-1:0]    count;
   logic [CNT_W-1:0]    first_full;
   logic                slot_hit;
   logic                slot_free;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   always_comb begin
      if ({3'b000, active_slots_ff} > 8'(MAX_SLOTS)) begin
         count = MAX_CNT;
      end else begin
         count = CNT_W'(active_slots_ff);
      end
      first_full = MAX_CNT - count;
   end

   assign cur_slot  = rd_valid_ff ? rd_data_ff : SLOT_FREE;
   assign slot_hit  = (cur_slot.range_base == rq_start_ff) &&
                      (cur_slot.range_end == rq_end_ff);
   assign slot_free = (cur_slot.owner == DOMAIN_NONE) &&
                      (cur_slot.range_base == FREE_ADDR) &&
                      (cur_slot.range_end == FREE_ADDR);

   always_comb begin
      state_in    = state_ff;
      scan_idx_in = scan_idx_ff;
      cmp_idx_in  = cmp_idx_ff;
      cmp_ok_in   = cmp_ok_ff;
      first_in    = first_ff;
      pick_in     = pick_ff;
      found_in    = found_ff;
      freed_in    = freed_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               first_in    = first_full[IDX_W-1:0];
               scan_idx_in = first_full[IDX_W-1:0];
               cmp_ok_in   = 1'b0;
               found_in    = 1'b0;
               freed_in    = 1'b0;
               pick_in     = '0;
               state_in    = (count == '0) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmp_ok_in  = 1'b1;
            cmp_idx_in = scan_idx_ff;
            if (scan_idx_ff != LAST_IDX) begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
            if (cmp_ok_ff) begin
               // An exact match anywhere beats an earlier free slot.
               if (slot_hit) begin
                  pick_in  = cmp_idx_ff;
                  found_in = 1'b1;
                  freed_in = (rq_owner_ff == DOMAIN_APPS_NS);
                  state_in = ST_FINISH;
               end else begin
                  if (slot_free && !found_ff) begin
                     pick_in  = cmp_idx_ff;
                     found_in = 1'b1;
                  end
                  if (cmp_idx_ff == LAST_IDX) begin
                     state_in = ST_FINISH;
                  end
               end
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cmp_ok_ff <= 1'b0;
         found_ff  <= 1'b0;
         freed_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cmp_ok_ff <= cmp_ok_in;
         found_ff  <= found_in;
         freed_ff  <= freed_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      first_ff    <= first_in;
      pick_ff     <= pick_in;
      if (accept) begin
         rq_start_ff <= req_start_address;
         rq_end_ff   <= req_end_address;
         rq_owner_ff <= req_owner_domain;
         rq_read_ff  <= req_read_domain;
         rq_write_ff <= req_write_domain;
      end
   end

   // A released slot is written back with the free pattern.
   always_comb begin
      if (freed_ff) begin
         wr_entry = SLOT_FREE;
      end else begin
         wr_entry.range_base = rq_start_ff;
         wr_entry.range_end  = rq_end_ff;
         wr_entry.owner      = rq_owner_ff;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_FINISH) && found_ff) begin
         slot_mem[pick_ff] <= wr_entry;
      end
      rd_data_ff <= slot_mem[scan_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         rd_valid_ff   <= 1'b0;
      end else begin
         if ((state_ff == ST_FINISH) && found_ff) begin
            slot_valid_ff[pick_ff] <= 1'b1;
         end
         rd_valid_ff <= slot_valid_ff[scan_idx_ff];
      end
   end

   // Result registers.
   logic                rsp_strobe_ff;
   logic                rsp_status_ff;
   logic [REGION_W-1:0] rsp_region_ff;
   logic                rsp_freed_ff;
   logic [DOMAIN_W-1:0] rsp_read_ff, rsp_write_ff;
   logic [IDX_W-1:0]    pick_offset;

   assign pick_offset = pick_ff - first_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (state_ff == ST_FINISH);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FINISH) begin
         if (found_ff) begin
            rsp_status_ff <= 1'b0;
            rsp_region_ff <= REGION_W'(region_base_ff) + REGION_W'(pick_offset);
            rsp_freed_ff  <= freed_ff;
            rsp_read_ff   <= rq_read_ff;
            rsp_write_ff  <= rq_write_ff;
         end else begin
            rsp_status_ff <= 1'b1;
            rsp_region_ff <= '0;
            rsp_freed_ff  <= 1'b0;
            rsp_read_ff   <= '0;
            rsp_write_ff  <= '0;
         end
      end
   end

   assign rsp_strobe            = rsp_strobe_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_region_number     = rsp_region_ff;
   assign rsp_slot_freed        = rsp_freed_ff;
   assign rsp_lock_read_domain  = rsp_read_ff;
   assign rsp_lock_write_domain = rsp_write_ff;

   // Assertions.
   a_strobe_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == ST_FINISH))
      else $error("result strobe without a finished request");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted request did not raise busy");

   a_pick_in_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) && found_ff |-> (pick_ff >= first_ff))
      else $error("chosen slot lies outside the active part");

   a_freed_needs_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) && freed_ff |-> found_ff && (rq_owner_ff == DOMAIN_APPS_NS))
      else $error("slot released without an exact match by the releasing owner");

endmodule
